// File: design/slbp_pkg.sv
// Shared types and constants for the status LED and buzzer pattern generator.
package slbp_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned FreqW   = 12;
  localparam int unsigned DurW    = 10;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Device status codes
  localparam logic [StatusW-1:0] ST_INIT        = 3'd0;
  localparam logic [StatusW-1:0] ST_STARTUP     = 3'd1;
  localparam logic [StatusW-1:0] ST_NO_SIM      = 3'd2;
  localparam logic [StatusW-1:0] ST_NO_NETWORK  = 3'd3;
  localparam logic [StatusW-1:0] ST_NO_INTERNET = 3'd4;
  localparam logic [StatusW-1:0] ST_NO_GPS      = 3'd5;
  localparam logic [StatusW-1:0] ST_HAS_GPS     = 3'd6;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BLINK_HALF = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_BRIGHTNESS = 1'd1;

  localparam logic [PeriodW-1:0] BLINK_HALF_RST = 16'd500;
  localparam logic [LevelW-1:0]  BRIGHTNESS_RST = 8'd50;

  // Beep phases
  localparam logic [PhaseW-1:0] PH_0 = 2'd0;
  localparam logic [PhaseW-1:0] PH_1 = 2'd1;
  localparam logic [PhaseW-1:0] PH_2 = 2'd2;
  localparam logic [PhaseW-1:0] PH_3 = 2'd3;

  // Tone frequencies and durations
  localparam logic [FreqW-1:0] F_1000 = 12'd1000;
  localparam logic [FreqW-1:0] F_1500 = 12'd1500;
  localparam logic [FreqW-1:0] F_2000 = 12'd2000;
  localparam logic [DurW-1:0]  D_100  = 10'd100;
  localparam logic [DurW-1:0]  D_200  = 10'd200;
  localparam logic [DurW-1:0]  D_500  = 10'd500;

  // Wait thresholds (strictly greater than)
  localparam logic [TimeW-1:0] W_STARTUP_STEP = 32'd150;
  localparam logic [TimeW-1:0] W_STARTUP_END  = 32'd250;
  localparam logic [TimeW-1:0] W_NO_SIM       = 32'd300;
  localparam logic [TimeW-1:0] W_LONG         = 32'd3000;
  localparam logic [TimeW-1:0] W_SECOND_BEEP  = 32'd200;

  typedef struct packed {
    logic             start;
    logic [FreqW-1:0] freq_hz;
    logic [DurW-1:0]  duration_ms;
  } tone_t;

  typedef struct packed {
    logic [TimeW-1:0]  last_beep_time;
    logic [PhaseW-1:0] beep_phase;
  } beep_state_t;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } pixel_t;

endpackage

// File: design/slbp_led.sv
// Blink toggle update and status pixel colour.
module slbp_led
  import slbp_pkg::*;
(
  input  logic [TimeW-1:0]   now_ms,
  input  logic [StatusW-1:0] device_status,
  input  logic [PeriodW-1:0] blink_half_period_ms,
  input  logic [LevelW-1:0]  led_brightness,
  input  logic               blink_on,
  input  logic [TimeW-1:0]   last_blink_time,
  output logic               blink_on_nxt,
  output logic [TimeW-1:0]   last_blink_time_nxt,
  output pixel_t             pixel
);

  logic [TimeW-1:0] elapsed;
  logic             flip;
  logic             r, g, b, blinks;

  assign elapsed = now_ms - last_blink_time;
  assign flip    = elapsed > {{(TimeW-PeriodW){1'b0}}, blink_half_period_ms};
  assign blink_on_nxt        = flip ? !blink_on : blink_on;
  assign last_blink_time_nxt = flip ? now_ms : last_blink_time;

  always_comb begin
    r = 1'b0;
    g = 1'b0;
    b = 1'b0;
    blinks = 1'b0;
    case (device_status)
      ST_NO_SIM: begin
        r = 1'b1;
        b = 1'b1;
        blinks = 1'b1;
      end
      ST_NO_INTERNET: begin
        r = 1'b1;
        g = 1'b1;
        blinks = 1'b1;
      end
      ST_NO_GPS: b = 1'b1;
      ST_HAS_GPS: g = 1'b1;
      default: r = 1'b1;
    endcase
    // blank a blinking colour in its off half
    if (blinks && !blink_on_nxt) begin
      r = 1'b0;
      g = 1'b0;
      b = 1'b0;
    end
  end

  assign pixel.red   = r ? led_brightness : '0;
  assign pixel.green = g ? led_brightness : '0;
  assign pixel.blue  = b ? led_brightness : '0;

endmodule

// File: design/slbp_beep.sv
// Buzzer pattern step: tone command, startup end flag and next beep state.
module slbp_beep
  import slbp_pkg::*;
(
  input  logic [TimeW-1:0]   now_ms,
  input  logic [StatusW-1:0] device_status,
  input  beep_state_t        beep_state,
  output beep_state_t        beep_state_nxt,
  output tone_t              tone,
  output logic               status_change
);

  logic [TimeW-1:0]  elapsed;
  logic [PhaseW-1:0] phase;
  logic              long_gap;

  assign elapsed  = now_ms - beep_state.last_beep_time;
  assign phase    = beep_state.beep_phase;
  assign long_gap = elapsed > W_LONG;

  always_comb begin
    beep_state_nxt = beep_state;
    tone           = '0;
    status_change  = 1'b0;
    case (device_status)
      ST_STARTUP: begin
        if (phase == PH_0) begin
          tone = '{1'b1, F_1000, D_100};
          beep_state_nxt = '{now_ms, PH_1};
        end else if (phase == PH_1 && elapsed > W_STARTUP_STEP) begin
          tone = '{1'b1, F_1500, D_100};
          beep_state_nxt = '{now_ms, PH_2};
        end else if (phase == PH_2 && elapsed > W_STARTUP_STEP) begin
          tone = '{1'b1, F_2000, D_200};
          beep_state_nxt = '{now_ms, PH_3};
        end else if (phase == PH_3 && elapsed > W_STARTUP_END) begin
          status_change = 1'b1;
          beep_state_nxt.beep_phase = PH_0;
        end
      end
      ST_NO_SIM: begin
        if (elapsed > W_NO_SIM) begin
          tone = '{1'b1, F_2000, D_100};
          beep_state_nxt.last_beep_time = now_ms;
        end
      end
      ST_NO_NETWORK: begin
        if (long_gap) begin
          tone = '{1'b1, F_1000, D_500};
          beep_state_nxt.last_beep_time = now_ms;
        end
      end
      ST_NO_INTERNET: begin
        // a long gap restarts the double beep at its first tone
        if (long_gap || phase == PH_1) begin
          tone = '{1'b1, F_1500, D_100};
          beep_state_nxt = '{now_ms, PH_2};
        end else if (phase == PH_2 && elapsed > W_SECOND_BEEP) begin
          tone = '{1'b1, F_1500, D_100};
          beep_state_nxt.beep_phase = PH_0;
        end
      end
      ST_HAS_GPS: beep_state_nxt.beep_phase = PH_0;
      default: begin
      end
    endcase
  end

endmodule

// File: design/status_led_buzzer_pattern_generator.sv
// Top level of the status LED and buzzer pattern generator.
//
// Each input transaction is one update tick (millisecond time and device
// status); each produces exactly one output transaction with the pixel
// colour, an optional tone command and the startup-done flag. A tick lands
// in an input register, then compare and subtract logic updates the blink
// and beep state and loads the result register, so the block takes one
// transaction per cycle while the output is not stalled by out_tready; a
// tick waits in the input register while the result register is held. The
// input side keeps accepting while a finished result waits, as long as the
// result register is free or being drained in the same cycle.
module status_led_buzzer_pattern_generator
  import slbp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [31:0] now_ms, [34:32] device_status, [39:35] zero
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [7:0] led_red, [15:8] led_green, [23:16] led_blue, [24] tone_start,
  // [36:25] tone_freq_hz, [46:37] tone_duration_ms, [47] status_change
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // configuration
  logic [PeriodW-1:0] blink_half_r;
  logic [LevelW-1:0]  brightness_r;

  // input stage
  logic               in_vld_r;
  logic [TimeW-1:0]   now_r;
  logic [StatusW-1:0] status_r;

  // pattern state
  logic               blink_on_r, blink_on_nxt;
  logic [TimeW-1:0]   last_blink_r, last_blink_nxt;
  beep_state_t        beep_r, beep_nxt;

  // result stage
  logic                out_vld_r;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;

  pixel_t pixel;
  tone_t  tone;
  logic   change;
  logic   advance;
  logic   fire;

  // the result register is free or empties this cycle
  assign advance   = !out_vld_r || out_tready;
  assign fire      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  slbp_led u_led (
    .now_ms               (now_r),
    .device_status        (status_r),
    .blink_half_period_ms (blink_half_r),
    .led_brightness       (brightness_r),
    .blink_on             (blink_on_r),
    .last_blink_time      (last_blink_r),
    .blink_on_nxt         (blink_on_nxt),
    .last_blink_time_nxt  (last_blink_nxt),
    .pixel                (pixel)
  );

  slbp_beep u_beep (
    .now_ms         (now_r),
    .device_status  (status_r),
    .beep_state     (beep_r),
    .beep_state_nxt (beep_nxt),
    .tone           (tone),
    .status_change  (change)
  );

  assign out_data_nxt = {change, tone.duration_ms, tone.freq_hz, tone.start,
                         pixel.blue, pixel.green, pixel.red};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_half_r <= BLINK_HALF_RST;
      brightness_r <= BRIGHTNESS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BLINK_HALF: blink_half_r <= cfg_wdata[PeriodW-1:0];
        CFG_BRIGHTNESS: brightness_r <= cfg_wdata[LevelW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register: load on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      now_r    <= in_tdata[TimeW-1:0];
      status_r <= in_tdata[TimeW+StatusW-1:TimeW];
    end
  end

  // pattern state: advance once per processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_on_r   <= 1'b0;
      last_blink_r <= '0;
      beep_r       <= '0;
    end else if (fire) begin
      blink_on_r   <= blink_on_nxt;
      last_blink_r <= last_blink_nxt;
      beep_r       <= beep_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
